@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg: shared definitions for the subsystem state consensus core
// Operation codes, register indexes, reset values, channel widths and the
// control state type used by the core.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int NUM_SUBSYSTEMS_DEF    = 8;
    localparam int NUM_SYSTEM_STATES_DEF = 8;
    localparam int MAP_SLOTS_DEF         = 8;

    // Field widths
    localparam int SUB_STATE_W = 8;
    localparam int STATE_W     = 3;
    localparam int REQ_W       = 4;
    localparam int MAP_ENTRY_W = SUB_STATE_W + STATE_W;

    // Channel widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_DATA_W = 8;

    // Special values
    localparam logic [SUB_STATE_W-1:0] UNINIT_SUB = 8'hFF;
    localparam logic [REQ_W-1:0]       NO_REQUEST = 4'd8;
    localparam logic [STATE_W-1:0]     INIT_STATE = 3'd0;

    // Register reset values
    localparam logic [7:0]         PRIORITY_MASK_RST = 8'd193;
    localparam logic [STATE_W-1:0] START_REQUEST_RST = 3'd2;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_MAP     = 2'd0,
        OP_REPORT  = 2'd1,
        OP_REQUEST = 2'd2,
        OP_RESET   = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_PRIORITY_MASK = 1'b0,
        CFG_START_REQUEST = 1'b1
    } cfg_idx_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE
    } ctrl_state_t;

endpackage

@@ rtl/subsystem_state_consensus_core.sv @@
// ----------------------------------------------------------------------------
// subsystem_state_consensus_core: system state voting over subsystem maps
// Keeps each subsystem's reported sub-state and a table of (sub-state,
// system-state) pairs per subsystem, and works out the system state.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser is the kind (map entry, report, state
//   request, reset), s_tlast marks the last map slot of a registration.
//   m_* returns exactly one result per request: system state, pending
//   request and the changed / notify / conflict / rejected flags.
//   cfg_* writes priority_mask (index 0) and start_request (index 1);
//   cfg_ready is always high. Write only while the core is idle.
// Request handling:
//   Map entry, state request, reset and refused reports: result is
//   registered at the accept edge, one request a cycle while results drain.
//   Accepted report: when any subsystem is left uninitialised the result
//   is loaded from the check state; otherwise the map is walked and the
//   decide state loads the result. No new request is taken meanwhile.
//   The map memory is walked one entry a cycle through its single read
//   port; each subsystem adds a load step to fetch its sub-state and
//   count and a closing step to close its vote.
// Reset (aresetn low, synchronous): every subsystem uninitialised, system
//   state init, request loaded with the start_request reset value, registers to defaults.
//   Map contents are kept undefined; no clearing pass is needed.
// A stalled m_tready holds the result; s_tready stays low until it drains.
// ----------------------------------------------------------------------------
module subsystem_state_consensus_core #(
    parameter int NUM_SUBSYSTEMS    = ssc_pkg::NUM_SUBSYSTEMS_DEF,
    parameter int NUM_SYSTEM_STATES = ssc_pkg::NUM_SYSTEM_STATES_DEF,
    parameter int MAP_SLOTS         = ssc_pkg::MAP_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] sub_fsm, [5:3] slot, [13:6] sub_code, [16:14] target_state
    input  logic [ssc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [ssc_pkg::S_TUSER_W-1:0]   s_tuser,
    // slot_last
    input  logic                            s_tlast,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] sys_state, [6:3] requested_state, [7] changed, [8] notify,
    // [9] conflict, [10] rejected
    output logic [ssc_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssc_pkg::*;

    localparam int SUB_W     = (NUM_SUBSYSTEMS > 1) ? $clog2(NUM_SUBSYSTEMS) : 1;
    localparam int MAP_DEPTH = NUM_SUBSYSTEMS * MAP_SLOTS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAP_SLOTS + 1);
    localparam int PRIO_N    = (NUM_SYSTEM_STATES < 8) ? NUM_SYSTEM_STATES : 8;
    localparam logic [MAP_AW-1:0] SLOTS_A  = MAP_AW'(MAP_SLOTS);
    localparam logic [SUB_W-1:0]  LAST_SUB = SUB_W'(NUM_SUBSYSTEMS - 1);

    // Request fields
    logic [2:0]             in_sub;
    logic [2:0]             in_slot;
    logic [SUB_STATE_W-1:0] in_sub_state;
    logic [STATE_W-1:0]     in_target;
    logic [SUB_W-1:0]       sub_idx;
    logic                   sub_ok;
    logic                   slot_ok;
    logic                   in_accept;

    assign in_sub       = s_tdata[2:0];
    assign in_slot      = s_tdata[5:3];
    assign in_sub_state = s_tdata[13:6];
    assign in_target    = s_tdata[16:14];
    assign sub_idx      = SUB_W'(in_sub);
    assign sub_ok       = (int'(in_sub) < NUM_SUBSYSTEMS);
    assign slot_ok      = (int'(in_slot) < MAP_SLOTS);

    // Configuration registers
    logic [7:0]         prio_mask_reg;
    logic [STATE_W-1:0] start_req_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_mask_reg <= PRIORITY_MASK_RST;
            start_req_reg <= START_REQUEST_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRIORITY_MASK: prio_mask_reg <= cfg_data;
                CFG_START_REQUEST: start_req_reg <= cfg_data[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Memories: map table, per-subsystem sub-state and map count
    logic [MAP_ENTRY_W-1:0] map_mem [MAP_DEPTH];
    logic [SUB_STATE_W-1:0] sub_mem [NUM_SUBSYSTEMS];
    logic [CNT_W-1:0]       cnt_mem [NUM_SUBSYSTEMS];

    logic                   map_we;
    logic [MAP_AW-1:0]      map_waddr;
    logic                   map_re;
    logic [MAP_AW-1:0]      map_raddr;
    logic                   sub_we;
    logic [SUB_STATE_W-1:0] sub_wdata;
    logic                   cnt_we;
    logic [CNT_W-1:0]       cnt_wdata;
    logic                   sub_re;

    logic [MAP_ENTRY_W-1:0] map_q_reg;
    logic [SUB_STATE_W-1:0] sub_q_reg;
    logic [CNT_W-1:0]       cnt_q_reg;

    // Control and result state
    ctrl_state_t                  state_reg, state_next;
    logic [STATE_W-1:0]           current_reg, current_next;
    logic [REQ_W-1:0]             pending_reg, pending_next;
    logic [NUM_SUBSYSTEMS-1:0]    init_bits_reg, init_bits_next;
    logic [SUB_W-1:0]             sub_cnt_reg, sub_cnt_next;
    logic [CNT_W-1:0]             slot_cnt_reg, slot_cnt_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [NUM_SYSTEM_STATES-1:0] cur_vote_reg, cur_vote_next;
    logic [NUM_SYSTEM_STATES-1:0] any_vote_reg, any_vote_next;
    logic [NUM_SYSTEM_STATES-1:0] all_vote_reg, all_vote_next;

    logic               out_valid_reg, out_valid_next;
    logic [STATE_W-1:0] out_state_reg, out_state_next;
    logic [REQ_W-1:0]   out_req_reg, out_req_next;
    logic               out_changed_reg, out_changed_next;
    logic               out_notify_reg, out_notify_next;
    logic               out_conflict_reg, out_conflict_next;
    logic               out_rejected_reg, out_rejected_next;

    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_rejected_reg, out_conflict_reg, out_notify_reg,
                       out_changed_reg, out_req_reg, out_state_reg};

    // Memory ports
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= {in_target, in_sub_state};
        end
        if (map_re) begin
            map_q_reg <= map_mem[map_raddr];
        end
        if (sub_we) begin
            sub_mem[sub_idx] <= sub_wdata;
        end
        if (cnt_we) begin
            cnt_mem[sub_idx] <= cnt_wdata;
        end
        if (sub_re) begin
            sub_q_reg <= sub_mem[sub_cnt_reg];
            cnt_q_reg <= cnt_mem[sub_cnt_reg];
        end
    end

    // Sequencer and result logic
    always_comb begin
        logic               issue;
        logic               hit;
        logic [NUM_SYSTEM_STATES-1:0] cur_upd;
        logic               sys_go;
        logic [STATE_W-1:0] sys_st;
        logic               out_load;
        logic               res_changed;
        logic               res_notify;
        logic               res_conflict;
        logic               res_rejected;
        logic               prio_hit;
        logic [STATE_W-1:0] prio_st;
        logic               req_hit;
        logic               full_seen;
        logic               full_many;
        logic [STATE_W-1:0] full_st;

        state_next     = state_reg;
        current_next   = current_reg;
        pending_next   = pending_reg;
        init_bits_next = init_bits_reg;
        sub_cnt_next   = sub_cnt_reg;
        slot_cnt_next  = slot_cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cur_vote_next  = cur_vote_reg;
        any_vote_next  = any_vote_reg;
        all_vote_next  = all_vote_reg;

        map_we    = 1'b0;
        map_waddr = MAP_AW'(in_sub) * SLOTS_A + MAP_AW'(in_slot);
        map_re    = 1'b0;
        map_raddr = MAP_AW'(sub_cnt_reg) * SLOTS_A + MAP_AW'(slot_cnt_reg);
        sub_we    = 1'b0;
        sub_wdata = in_sub_state;
        cnt_we    = 1'b0;
        cnt_wdata = CNT_W'(4'({1'b0, in_slot} + 4'd1));
        sub_re    = 1'b0;

        issue        = 1'b0;
        hit          = 1'b0;
        cur_upd      = cur_vote_reg;
        sys_go       = 1'b0;
        sys_st       = INIT_STATE;
        out_load     = 1'b0;
        res_changed  = 1'b0;
        res_notify   = 1'b0;
        res_conflict = 1'b0;
        res_rejected = 1'b0;
        prio_hit     = 1'b0;
        prio_st      = INIT_STATE;
        req_hit      = 1'b0;
        full_seen    = 1'b0;
        full_many    = 1'b0;
        full_st      = INIT_STATE;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (op_t'(s_tuser))
                        OP_MAP: begin
                            // write the entry; last slot completes registration
                            out_load = 1'b1;
                            if (sub_ok && slot_ok) begin
                                map_we = 1'b1;
                                if (s_tlast) begin
                                    cnt_we    = 1'b1;
                                    sub_we    = 1'b1;
                                    sub_wdata = '0;
                                    init_bits_next[sub_idx] = 1'b1;
                                end
                            end
                        end
                        OP_REPORT: begin
                            if (!sub_ok || !init_bits_reg[sub_idx]) begin
                                out_load     = 1'b1;
                                res_rejected = 1'b1;
                            end else begin
                                sub_we = 1'b1;
                                init_bits_next[sub_idx] = (in_sub_state != UNINIT_SUB);
                                state_next = ST_CHECK;
                            end
                        end
                        OP_REQUEST: begin
                            out_load = 1'b1;
                            if (pending_reg != {1'b0, in_target}) begin
                                pending_next = {1'b0, in_target};
                                res_notify   = 1'b1;
                            end
                        end
                        OP_RESET: begin
                            out_load       = 1'b1;
                            current_next   = INIT_STATE;
                            pending_next   = {1'b0, start_req_reg};
                            init_bits_next = '0;
                            res_changed    = (current_reg != INIT_STATE);
                            res_notify     = res_changed ||
                                             (pending_reg != {1'b0, start_req_reg});
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                // any subsystem uninitialised forces init, else start the walk
                if (!(&init_bits_reg)) begin
                    sys_go     = 1'b1;
                    sys_st     = INIT_STATE;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    sub_cnt_next  = '0;
                    any_vote_next = '0;
                    all_vote_next = '1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // fetch sub-state and map count of this subsystem
                sub_re        = 1'b1;
                slot_cnt_next = '0;
                cmp_vld_next  = 1'b0;
                cur_vote_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // compare the entry read last cycle, issue the next read
                hit = cmp_vld_reg && (map_q_reg[SUB_STATE_W-1:0] == sub_q_reg);
                for (int i = 0; i < NUM_SYSTEM_STATES; i++) begin
                    if (hit && (int'(map_q_reg[MAP_ENTRY_W-1:SUB_STATE_W]) == i)) begin
                        cur_upd[i] = 1'b1;
                    end
                end
                issue = (slot_cnt_reg < cnt_q_reg);
                if (issue) begin
                    map_re        = 1'b1;
                    slot_cnt_next = slot_cnt_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                    cur_vote_next = cur_upd;
                end else begin
                    // close this subsystem's votes
                    any_vote_next = any_vote_reg | cur_upd;
                    all_vote_next = all_vote_reg & cur_upd;
                    cmp_vld_next  = 1'b0;
                    cur_vote_next = '0;
                    if (sub_cnt_reg == LAST_SUB) begin
                        state_next = ST_DECIDE;
                    end else begin
                        sub_cnt_next = sub_cnt_reg + SUB_W'(1);
                        state_next   = ST_LOAD;
                    end
                end
            end
            ST_DECIDE: begin
                // priority state, then request, then single full consensus
                for (int i = 0; i < PRIO_N; i++) begin
                    if (any_vote_reg[i] && prio_mask_reg[i]) begin
                        prio_hit = 1'b1;
                        prio_st  = STATE_W'(i);
                    end
                end
                for (int i = 0; i < NUM_SYSTEM_STATES; i++) begin
                    if ((int'(pending_reg) == i) && all_vote_reg[i]) begin
                        req_hit = 1'b1;
                    end
                    if (all_vote_reg[i]) begin
                        if (full_seen) begin
                            full_many = 1'b1;
                        end
                        full_seen = 1'b1;
                        full_st   = STATE_W'(i);
                    end
                end
                out_load   = 1'b1;
                state_next = ST_IDLE;
                if (prio_hit) begin
                    sys_go = 1'b1;
                    sys_st = prio_st;
                end else if (req_hit) begin
                    sys_go = 1'b1;
                    sys_st = pending_reg[STATE_W-1:0];
                end else if (full_seen && !full_many) begin
                    sys_go = 1'b1;
                    sys_st = full_st;
                end else if (full_many) begin
                    res_conflict = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // move the system state; reaching the request clears it
        if (sys_go && (current_reg != sys_st)) begin
            current_next = sys_st;
            if (pending_reg == {1'b0, sys_st}) begin
                pending_next = NO_REQUEST;
            end
            res_changed = 1'b1;
            res_notify  = 1'b1;
        end

        // result register
        out_valid_next    = out_valid_reg && !m_tready;
        out_state_next    = out_state_reg;
        out_req_next      = out_req_reg;
        out_changed_next  = out_changed_reg;
        out_notify_next   = out_notify_reg;
        out_conflict_next = out_conflict_reg;
        out_rejected_next = out_rejected_reg;
        if (out_load) begin
            out_valid_next    = 1'b1;
            out_state_next    = current_next;
            out_req_next      = pending_next;
            out_changed_next  = res_changed;
            out_notify_next   = res_notify;
            out_conflict_next = res_conflict;
            out_rejected_next = res_rejected;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            current_reg   <= INIT_STATE;
            pending_reg   <= {1'b0, START_REQUEST_RST};
            init_bits_reg <= '0;
            sub_cnt_reg   <= '0;
            slot_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            current_reg   <= current_next;
            pending_reg   <= pending_next;
            init_bits_reg <= init_bits_next;
            sub_cnt_reg   <= sub_cnt_next;
            slot_cnt_reg  <= slot_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vote vectors and result payload
    always_ff @(posedge aclk) begin
        cur_vote_reg     <= cur_vote_next;
        any_vote_reg     <= any_vote_next;
        all_vote_reg     <= all_vote_next;
        out_state_reg    <= out_state_next;
        out_req_reg      <= out_req_next;
        out_changed_reg  <= out_changed_next;
        out_notify_reg   <= out_notify_next;
        out_conflict_reg <= out_conflict_next;
        out_rejected_reg <= out_rejected_next;
    end

    // Checks
    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("result pending while a report is being resolved");

    a_changed_notifies: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_changed_reg) |-> out_notify_reg)
        else $error("state change without notify");

    a_rejected_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rejected_reg) |->
            (!out_changed_reg && !out_notify_reg && !out_conflict_reg))
        else $error("refused report moved the state");

    a_conflict_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_conflict_reg) |-> !out_changed_reg)
        else $error("conflict with a state change");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (slot_cnt_reg <= cnt_q_reg))
        else $error("map walk ran past the subsystem count");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for subsystem_state_consensus_core
// Streams registration, report, state request and reset requests into the
// core, predicts every result from a local copy of the voting state, and
// checks each returned result field by field in order. Runs a directed
// opening, then three random phases with different register settings and
// flow-control pacing, including a long result stall.
// ----------------------------------------------------------------------------
module tb_top;
    import ssc_pkg::*;

    localparam int N_SUB      = NUM_SUBSYSTEMS_DEF;
    localparam int N_STATES   = NUM_SYSTEM_STATES_DEF;
    localparam int N_SLOTS    = MAP_SLOTS_DEF;
    localparam int HOLD_AT    = 560;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_WAIT  = 100;

    // One request on the input channel
    typedef struct packed {
        op_t        op;
        logic [2:0] sub_fsm;
        logic [2:0] slot;
        logic       slot_last;
        logic [7:0] sub_code;
        logic [2:0] target_state;
    } ssc_request_t;

    // One result, sys_state in the lowest bits
    typedef struct packed {
        logic       rejected;
        logic       conflict;
        logic       notify;
        logic       changed;
        logic [3:0] requested_state;
        logic [2:0] sys_state;
    } ssc_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [S_TUSER_W-1:0]    s_tuser = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_idx_t                cfg_index = CFG_PRIORITY_MASK;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    subsystem_state_consensus_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Pending requests, expected results and bookkeeping
    ssc_request_t pending_q[$];
    ssc_result_t  expected_q[$];
    ssc_request_t offer_req;
    int           fail_count = 0;
    int           results_seen = 0;
    int           planned = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    // Predicted core state
    logic [7:0]   prio_mask;
    logic [2:0]   start_req;
    logic [7:0]   sub_ss [N_SUB];
    logic [7:0]   map_ss [N_SUB][N_SLOTS];
    logic [2:0]   map_st [N_SUB][N_SLOTS];
    logic [3:0]   map_cnt [N_SUB];
    logic [2:0]   sys_now;
    logic [3:0]   req_now;

    // Stimulus planning view: what has been queued so far
    bit           plan_written [N_SUB][N_SLOTS];
    bit           plan_live [N_SUB];
    int           plan_cnt [N_SUB];
    logic [7:0]   plan_ss [N_SUB][N_SLOTS];
    int           row_ss [N_SLOTS];
    int           row_tgt [N_SLOTS];

    // Return sub-states, counts, state and request to their reset values
    function automatic void clear_consensus_state();
        foreach (sub_ss[f]) begin
            sub_ss[f]  = UNINIT_SUB;
            map_cnt[f] = '0;
        end
        sys_now = INIT_STATE;
        req_now = {1'b0, start_req};
    endfunction

    // Apply one request to the predicted state and return its result
    function automatic ssc_result_t predict_consensus(input ssc_request_t r);
        ssc_result_t      res;
        logic [N_SUB-1:0] votes [N_STATES];
        logic [2:0]       old_sys;
        logic [3:0]       old_req;
        logic             any_uninit;
        logic             take;
        logic [2:0]       pick;
        int               hits;
        res = '0;
        old_sys = sys_now;
        old_req = req_now;
        case (r.op)
            OP_MAP: begin
                map_ss[r.sub_fsm][r.slot] = r.sub_code;
                map_st[r.sub_fsm][r.slot] = r.target_state;
                if (r.slot_last) begin
                    map_cnt[r.sub_fsm] = 4'(r.slot) + 4'd1;
                    sub_ss[r.sub_fsm]  = '0;
                end
            end
            OP_REPORT: begin
                if (sub_ss[r.sub_fsm] == UNINIT_SUB) begin
                    res.rejected = 1'b1;
                end else begin
                    sub_ss[r.sub_fsm] = r.sub_code;
                    any_uninit = 1'b0;
                    take = 1'b0;
                    pick = INIT_STATE;
                    hits = 0;
                    foreach (votes[s]) votes[s] = '0;
                    foreach (sub_ss[f]) if (sub_ss[f] == UNINIT_SUB) any_uninit = 1'b1;
                    if (any_uninit) begin
                        take = 1'b1;
                    end else begin
                        // gather votes from every valid map entry
                        for (int f = 0; f < N_SUB; f++)
                            for (int m = 0; m < int'(map_cnt[f]); m++)
                                if (map_ss[f][m] == sub_ss[f]) votes[map_st[f][m]][f] = 1'b1;
                        // the highest-numbered priority state with any vote wins
                        for (int s = 0; s < N_STATES; s++)
                            if (votes[s] != '0 && prio_mask[s]) begin
                                take = 1'b1;
                                pick = 3'(s);
                            end
                        // then the request, if everyone agrees on it
                        if (!take && req_now < N_STATES && votes[req_now[2:0]] == '1) begin
                            take = 1'b1;
                            pick = req_now[2:0];
                        end
                        // then a single unanimous state, or flag the conflict
                        if (!take) begin
                            for (int s = 0; s < N_STATES; s++)
                                if (votes[s] == '1) begin
                                    hits++;
                                    pick = 3'(s);
                                end
                            if (hits == 1) take = 1'b1;
                            else if (hits > 1) res.conflict = 1'b1;
                        end
                    end
                    if (take && pick != sys_now) begin
                        sys_now = pick;
                        if (req_now == {1'b0, pick}) req_now = NO_REQUEST;
                        res.changed = 1'b1;
                        res.notify  = 1'b1;
                    end
                end
            end
            OP_REQUEST: begin
                if (req_now != {1'b0, r.target_state}) begin
                    req_now = {1'b0, r.target_state};
                    res.notify = 1'b1;
                end
            end
            OP_RESET: begin
                clear_consensus_state();
                res.changed = (sys_now != old_sys);
                res.notify  = res.changed || (req_now != old_req);
            end
            default: ;
        endcase
        res.sys_state       = sys_now;
        res.requested_state = req_now;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Queue one request; a last mark that would expose unwritten slots is dropped
    task automatic push_request(input op_t op, input int sub, input int slot, input bit last,
                                input int ss, input int tgt);
        ssc_request_t r;
        bit           safe;
        safe = 1'b1;
        for (int j = 0; j < slot; j++) if (!plan_written[sub][j]) safe = 1'b0;
        r.op           = op;
        r.sub_fsm      = 3'(sub);
        r.slot         = 3'(slot);
        r.slot_last    = last && (op != OP_MAP || safe);
        r.sub_code     = 8'(ss);
        r.target_state = 3'(tgt);
        case (op)
            OP_MAP: begin
                plan_written[sub][slot] = 1'b1;
                plan_ss[sub][slot] = 8'(ss);
                if (r.slot_last) begin
                    plan_cnt[sub]  = slot + 1;
                    plan_live[sub] = 1'b1;
                end
            end
            OP_REPORT: if (ss == int'(UNINIT_SUB)) plan_live[sub] = 1'b0;
            OP_RESET: begin
                foreach (plan_live[f]) begin
                    plan_live[f] = 1'b0;
                    plan_cnt[f]  = 0;
                end
            end
            default: ;
        endcase
        pending_q.push_back(r);
        planned++;
    endtask

    // Pick fresh common rows so that subsystems tend to vote alike
    task automatic shuffle_rows();
        foreach (row_ss[j]) begin
            row_ss[j]  = $urandom_range(0, 3);
            row_tgt[j] = $urandom_range(0, N_STATES - 1);
        end
    endtask

    // Queue a complete registration for one subsystem, mostly short maps
    task automatic plan_registration(input int sub);
        int n;
        n = ($urandom_range(0, 7) == 0) ? N_SLOTS : $urandom_range(1, 3);
        for (int j = 0; j < n; j++)
            push_request(OP_MAP, sub, j, j == n - 1,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 254) : row_ss[j],
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : row_tgt[j]);
    endtask

    // Queue about n random requests, mostly well-formed sequences
    task automatic plan_random(input int n);
        int  stop;
        int  sub;
        int  pick;
        int  j;
        int  ss;
        int  rot;
        bit  all_live;
        stop = planned + n;
        shuffle_rows();
        while (planned < stop) begin
            all_live = 1'b1;
            foreach (plan_live[f]) if (!plan_live[f]) all_live = 1'b0;
            sub  = $urandom_range(0, N_SUB - 1);
            pick = $urandom_range(0, 99);
            if (!all_live && pick < 85) begin
                // register the next uninitialised subsystem
                while (plan_live[sub]) sub = (sub + 1) % N_SUB;
                plan_registration(sub);
            end else if (all_live && pick < 35) begin
                // sweep: every subsystem reports the same map row
                j   = $urandom_range(0, 2);
                rot = $urandom_range(0, N_SUB - 1);
                for (int f = 0; f < N_SUB; f++) begin
                    sub = (f + rot) % N_SUB;
                    if (plan_live[sub])
                        push_request(OP_REPORT, sub, $urandom_range(0, 7), $urandom_range(0, 1),
                                     plan_ss[sub][(j < plan_cnt[sub]) ? j : plan_cnt[sub] - 1],
                                     $urandom_range(0, 7));
                end
            end else if (all_live && pick < 70) begin
                // single report, now and then off the map or dropping out
                j = $urandom_range(0, 99);
                if (j < 2) ss = int'(UNINIT_SUB);
                else if (j < 10) ss = $urandom_range(0, 254);
                else ss = plan_ss[sub][$urandom_range(0, plan_cnt[sub] - 1)];
                push_request(OP_REPORT, sub, $urandom_range(0, 7), $urandom_range(0, 1), ss,
                             $urandom_range(0, 7));
            end else if (all_live && pick < 80) begin
                push_request(OP_REQUEST, sub, $urandom_range(0, 7), $urandom_range(0, 1),
                             $urandom_range(0, 254),
                             ($urandom_range(0, 1) == 0) ? row_tgt[$urandom_range(0, 2)]
                                                        : $urandom_range(0, 7));
            end else if (all_live && pick < 88) begin
                if ($urandom_range(0, 2) == 0) shuffle_rows();
                plan_registration(sub);
            end else if (all_live && pick < 91) begin
                push_request(OP_RESET, sub, $urandom_range(0, 7), $urandom_range(0, 1),
                             $urandom_range(0, 254), $urandom_range(0, 7));
                shuffle_rows();
            end else begin
                // noise: any kind with random fields
                push_request(op_t'($urandom_range(0, 3)), sub, $urandom_range(0, 7),
                             $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 7));
            end
        end
    endtask

    // Write one configuration register and mirror it in the prediction
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_PRIORITY_MASK) prio_mask = value;
        else start_req = value[2:0];
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued request has been answered
    task automatic wait_drained();
        do @(posedge aclk); while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    // Request driver: predict at acceptance, then offer the next request
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) expected_q.push_back(predict_consensus(offer_req));
        if (!s_tvalid || s_tready) begin
            if (aresetn && pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offer_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= offer_req.op;
                s_tlast  <= offer_req.slot_last;
                s_tdata  <= {7'd0, offer_req.target_state, offer_req.sub_code,
                             offer_req.slot, offer_req.sub_fsm};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result pacing, with one long hold-off to back the core up
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge aclk) begin : result_monitor
        ssc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result %h with no request outstanding", m_tdata);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("sys_state", 32'(want.sys_state), 32'(m_tdata[2:0]));
                check_field("requested_state", 32'(want.requested_state), 32'(m_tdata[6:3]));
                check_field("changed", 32'(want.changed), 32'(m_tdata[7]));
                check_field("notify", 32'(want.notify), 32'(m_tdata[8]));
                check_field("conflict", 32'(want.conflict), 32'(m_tdata[9]));
                check_field("rejected", 32'(want.rejected), 32'(m_tdata[10]));
            end
        end
    end

    // Watchdog: give up after a long stretch with no handshake anywhere
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        prio_mask = PRIORITY_MASK_RST;
        start_req = START_REQUEST_RST;
        clear_consensus_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening
        send_idle_pct = 15;
        recv_idle_pct = 88;
        write_reg(CFG_PRIORITY_MASK, 8'hC1);
        write_reg(CFG_START_REQUEST, 8'd2);
        push_request(OP_REPORT, 7, 0, 0, 254, 0);     // refused, not yet registered
        push_request(OP_REQUEST, 0, 0, 0, 0, 5);      // new request
        push_request(OP_REQUEST, 0, 0, 0, 0, 5);      // same request, no notify
        push_request(OP_MAP, 0, 0, 0, 254, 7);
        push_request(OP_MAP, 0, 1, 1, 0, 3);
        for (int f = 1; f < N_SUB; f++) push_request(OP_MAP, f, 0, 1, 0, 3);
        push_request(OP_REPORT, 0, 0, 0, 0, 0);       // unanimous vote
        push_request(OP_REPORT, 0, 0, 0, 254, 0);     // priority override
        push_request(OP_REQUEST, 0, 0, 0, 0, 3);
        push_request(OP_REPORT, 0, 0, 0, 0, 0);       // request reached and cleared
        push_request(OP_REPORT, 2, 0, 0, 255, 0);     // drops back to uninitialised
        push_request(OP_REPORT, 2, 0, 0, 0, 0);       // refused again
        push_request(OP_MAP, 3, 7, 0, 200, 6);        // top slot, not counted
        push_request(OP_RESET, 7, 7, 1, 255, 7);
        push_request(OP_REPORT, 0, 0, 0, 0, 0);       // refused after reset
        wait_drained();

        // Random, sender mostly busy, receiver mostly stalled
        write_reg(CFG_PRIORITY_MASK, 8'h00);
        write_reg(CFG_START_REQUEST, 8'd0);
        plan_random(250);
        wait_drained();

        // Random, pacing swapped, every state a priority state
        send_idle_pct = 88;
        recv_idle_pct = 15;
        write_reg(CFG_PRIORITY_MASK, 8'hFF);
        write_reg(CFG_START_REQUEST, 8'd7);
        plan_random(250);
        wait_drained();

        // Random, no idling, with a pause for the core to drain midway
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_PRIORITY_MASK, 8'($urandom_range(0, 255)));
        write_reg(CFG_START_REQUEST, 8'($urandom_range(0, 7)));
        plan_random(125);
        wait_drained();
        plan_random(125);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
